/* src/csrf_pkg.sv */
// ----------------------------------------------------------------------------
// csrf_pkg
// shared types and constants of the cube sum repeat finder
// ----------------------------------------------------------------------------
package csrf_pkg;

  localparam int HEAP_DEPTH_DEF = 32768;
  localparam int ROOT_WIDTH_DEF = 21;
  localparam int SUM_W          = 63;
  localparam int HIST_W         = 64;
  localparam int CNT_W          = 32;
  localparam int SIZE_W         = 16;
  localparam int PB_W           = 21;
  localparam logic [CNT_W-1:0] STOP_RESET = 32'd1000000;

  localparam logic [1:0] HALT_NONE  = 2'd0;
  localparam logic [1:0] HALT_FULL  = 2'd1;
  localparam logic [1:0] HALT_OVF   = 2'd2;
  localparam logic [1:0] HALT_STOP  = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_ROOT, ST_GET_ROOT, ST_GET_LAST, ST_SD_L, ST_SD_R,
    ST_SD_CMP2, ST_SD_CMP, ST_SD_PUT, ST_BASE_CHK, ST_PU_START, ST_PU_L,
    ST_PU_CMP, ST_PU_PUT, ST_BASE_ADV, ST_CUBE1, ST_CUBE1_W, ST_CUBE2,
    ST_CUBE2_W, ST_CUBE_ST, ST_FOUND, ST_SUCC_CHK, ST_SQ, ST_SQ_W, ST_B3,
    ST_B3_W, ST_SUCC, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_START, OP_RD_ROOT, OP_GET_ROOT, OP_GET_LAST, OP_SD_L,
    OP_SD_R, OP_SD_CMP2, OP_SD_CMP, OP_SD_PUT, OP_LOAD_BASE, OP_PU_START,
    OP_PU_L, OP_PU_CMP, OP_PU_PUT, OP_BASE_ADV, OP_CUBE1, OP_CUBE2,
    OP_MUL_STEP, OP_CUBE_ST, OP_FOUND, OP_SQ, OP_B3, OP_SUCC
  } op_t;

  typedef struct packed {
    logic can_step;
    logic fill_zero;
    logic has_left;
    logic has_right;
    logic right_less;
    logic child_less;
    logic at_root;
    logic up_less;
    logic b_zero;
    logic halted_nz;
    logic mul_done;
    logic succ_push;
  } status_t;

endpackage

/* src/csrf_ram.sv */
// ----------------------------------------------------------------------------
// csrf_ram
// generic ram, one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module csrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/csrf_ctrl.sv */
// ----------------------------------------------------------------------------
// csrf_ctrl
// sequencer for pop, sift down, pushes, cube updates and result strobe
// ----------------------------------------------------------------------------
module csrf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              step_request,
  input  csrf_pkg::status_t st,
  output csrf_pkg::op_t     op,
  output logic              busy,
  output logic              done
);

  csrf_pkg::state_t state, state_next;
  logic is_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= csrf_pkg::ST_IDLE;
      is_base <= 1'b0;
    end else begin
      state <= state_next;
      if (state == csrf_pkg::ST_BASE_CHK) begin
        is_base <= 1'b1;
      end else if (state == csrf_pkg::ST_SUCC) begin
        is_base <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      csrf_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (step_request && st.can_step) ? csrf_pkg::ST_RD_ROOT
                                                      : csrf_pkg::ST_DONE;
        end
      end
      csrf_pkg::ST_RD_ROOT:  state_next = csrf_pkg::ST_GET_ROOT;
      csrf_pkg::ST_GET_ROOT: begin
        state_next = st.fill_zero ? csrf_pkg::ST_BASE_CHK : csrf_pkg::ST_GET_LAST;
      end
      csrf_pkg::ST_GET_LAST: state_next = csrf_pkg::ST_SD_L;
      csrf_pkg::ST_SD_L: begin
        state_next = st.has_left ? csrf_pkg::ST_SD_R : csrf_pkg::ST_SD_PUT;
      end
      csrf_pkg::ST_SD_R: begin
        state_next = st.has_right ? csrf_pkg::ST_SD_CMP2 : csrf_pkg::ST_SD_CMP;
      end
      csrf_pkg::ST_SD_CMP2: state_next = csrf_pkg::ST_SD_CMP;
      csrf_pkg::ST_SD_CMP: begin
        state_next = st.child_less ? csrf_pkg::ST_SD_L : csrf_pkg::ST_SD_PUT;
      end
      csrf_pkg::ST_SD_PUT: state_next = csrf_pkg::ST_BASE_CHK;
      csrf_pkg::ST_BASE_CHK: begin
        state_next = st.b_zero ? csrf_pkg::ST_PU_START : csrf_pkg::ST_FOUND;
      end
      csrf_pkg::ST_PU_START: state_next = csrf_pkg::ST_PU_L;
      csrf_pkg::ST_PU_L: begin
        state_next = st.at_root ? csrf_pkg::ST_PU_PUT : csrf_pkg::ST_PU_CMP;
      end
      csrf_pkg::ST_PU_CMP: begin
        state_next = st.up_less ? csrf_pkg::ST_PU_L : csrf_pkg::ST_PU_PUT;
      end
      csrf_pkg::ST_PU_PUT: begin
        state_next = is_base ? csrf_pkg::ST_BASE_ADV : csrf_pkg::ST_DONE;
      end
      csrf_pkg::ST_BASE_ADV: begin
        state_next = st.halted_nz ? csrf_pkg::ST_FOUND : csrf_pkg::ST_CUBE1;
      end
      csrf_pkg::ST_CUBE1:   state_next = csrf_pkg::ST_CUBE1_W;
      csrf_pkg::ST_CUBE1_W: if (st.mul_done) state_next = csrf_pkg::ST_CUBE2;
      csrf_pkg::ST_CUBE2:   state_next = csrf_pkg::ST_CUBE2_W;
      csrf_pkg::ST_CUBE2_W: if (st.mul_done) state_next = csrf_pkg::ST_CUBE_ST;
      csrf_pkg::ST_CUBE_ST: state_next = csrf_pkg::ST_FOUND;
      csrf_pkg::ST_FOUND:   state_next = csrf_pkg::ST_SUCC_CHK;
      csrf_pkg::ST_SUCC_CHK: begin
        state_next = st.halted_nz ? csrf_pkg::ST_DONE : csrf_pkg::ST_SQ;
      end
      csrf_pkg::ST_SQ:   state_next = csrf_pkg::ST_SQ_W;
      csrf_pkg::ST_SQ_W: if (st.mul_done) state_next = csrf_pkg::ST_B3;
      csrf_pkg::ST_B3:   state_next = csrf_pkg::ST_B3_W;
      csrf_pkg::ST_B3_W: if (st.mul_done) state_next = csrf_pkg::ST_SUCC;
      csrf_pkg::ST_SUCC: begin
        state_next = st.succ_push ? csrf_pkg::ST_PU_START : csrf_pkg::ST_DONE;
      end
      csrf_pkg::ST_DONE: state_next = csrf_pkg::ST_IDLE;
      default:           state_next = csrf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op   = csrf_pkg::OP_NONE;
    busy = (state != csrf_pkg::ST_IDLE);
    done = (state == csrf_pkg::ST_DONE);
    unique case (state)
      csrf_pkg::ST_IDLE:     op = start ? csrf_pkg::OP_START : csrf_pkg::OP_NONE;
      csrf_pkg::ST_RD_ROOT:  op = csrf_pkg::OP_RD_ROOT;
      csrf_pkg::ST_GET_ROOT: op = csrf_pkg::OP_GET_ROOT;
      csrf_pkg::ST_GET_LAST: op = csrf_pkg::OP_GET_LAST;
      csrf_pkg::ST_SD_L:     op = csrf_pkg::OP_SD_L;
      csrf_pkg::ST_SD_R:     op = csrf_pkg::OP_SD_R;
      csrf_pkg::ST_SD_CMP2:  op = csrf_pkg::OP_SD_CMP2;
      csrf_pkg::ST_SD_CMP:   op = csrf_pkg::OP_SD_CMP;
      csrf_pkg::ST_SD_PUT:   op = csrf_pkg::OP_SD_PUT;
      csrf_pkg::ST_BASE_CHK: op = csrf_pkg::OP_LOAD_BASE;
      csrf_pkg::ST_PU_START: op = csrf_pkg::OP_PU_START;
      csrf_pkg::ST_PU_L:     op = csrf_pkg::OP_PU_L;
      csrf_pkg::ST_PU_CMP:   op = csrf_pkg::OP_PU_CMP;
      csrf_pkg::ST_PU_PUT:   op = csrf_pkg::OP_PU_PUT;
      csrf_pkg::ST_BASE_ADV: op = csrf_pkg::OP_BASE_ADV;
      csrf_pkg::ST_CUBE1:    op = csrf_pkg::OP_CUBE1;
      csrf_pkg::ST_CUBE2:    op = csrf_pkg::OP_CUBE2;
      csrf_pkg::ST_CUBE1_W,
      csrf_pkg::ST_CUBE2_W,
      csrf_pkg::ST_SQ_W,
      csrf_pkg::ST_B3_W:     op = csrf_pkg::OP_MUL_STEP;
      csrf_pkg::ST_CUBE_ST:  op = csrf_pkg::OP_CUBE_ST;
      csrf_pkg::ST_FOUND:    op = csrf_pkg::OP_FOUND;
      csrf_pkg::ST_SQ:       op = csrf_pkg::OP_SQ;
      csrf_pkg::ST_B3:       op = csrf_pkg::OP_B3;
      csrf_pkg::ST_SUCC:     op = csrf_pkg::OP_SUCC;
      default:               op = csrf_pkg::OP_NONE;
    endcase
  end

endmodule

/* src/csrf_dp.sv */
// ----------------------------------------------------------------------------
// csrf_dp
// heap memory, sift registers, shift-add multiplier and step bookkeeping
// ----------------------------------------------------------------------------
module csrf_dp #(
  parameter int HEAP_DEPTH = csrf_pkg::HEAP_DEPTH_DEF,
  parameter int ROOT_WIDTH = csrf_pkg::ROOT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  csrf_pkg::op_t                 op,
  input  logic                          cfg_we,
  input  logic [csrf_pkg::CNT_W-1:0]    cfg_data,
  output csrf_pkg::status_t             st,
  output logic [csrf_pkg::CNT_W-1:0]    stop_count,
  output logic                          found,
  output logic [csrf_pkg::SUM_W-1:0]    found_value,
  output logic [csrf_pkg::PB_W-1:0]     partner_b,
  output logic [csrf_pkg::CNT_W-1:0]    ordinal,
  output logic [csrf_pkg::SIZE_W-1:0]   heap_size,
  output logic [1:0]                    status
);

  localparam int SW = csrf_pkg::SUM_W;
  localparam int RW = ROOT_WIDTH;
  localparam int EW = SW + RW;
  localparam int IW = $clog2(HEAP_DEPTH);
  localparam int FW = $clog2(HEAP_DEPTH + 1);
  localparam int CW = $clog2(RW + 1);
  localparam int HW = csrf_pkg::HIST_W;

  // heap memory
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, ram_rdata, rd;
  logic          root_written, rd_init;

  csrf_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_heap (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(ram_rdata)
  );

  logic [SW-1:0] rd_sum;
  logic [RW-1:0] rd_root;
  assign rd      = rd_init ? {SW'(1), RW'(0)} : ram_rdata;
  assign rd_sum  = rd[EW-1:RW];
  assign rd_root = rd[RW-1:0];

  // state
  logic [FW-1:0]    fill;
  logic [IW-1:0]    idx, c_idx, par_idx;
  logic [SW-1:0]    s_pop, last_sum, c_sum, val_sum, base_cube;
  logic [RW-1:0]    b_pop, last_root, c_root, val_root, next_base;
  logic [HW-1:0]    prev, prev2;
  logic [csrf_pkg::CNT_W-1:0] found_total;
  logic [1:0]       halted;
  logic [SW-1:0]    mul_a, acc, b2;
  logic [RW-1:0]    mul_b;
  logic [CW-1:0]    mul_cnt;

  // derived
  logic [IW:0]   lch, rch;
  logic [FW:0]   fill_x;
  logic [IW-1:0] par;
  logic [HW-1:0] s_ext, b3x2, ns;
  logic          ovf, full, fnd;
  logic [csrf_pkg::CNT_W-1:0] ft_inc;

  assign lch    = {idx, 1'b1};
  assign rch    = lch + (IW+1)'(1);
  assign fill_x = {1'b0, fill};
  assign par    = (idx - IW'(1)) >> 1;
  assign s_ext  = {1'b0, s_pop};
  assign b3x2   = {acc, 1'b0};
  assign ns     = s_ext + HW'(1) + HW'(3) * (HW'(b_pop) + HW'(b2));
  assign ovf    = ns[HW-1] || (b_pop == {RW{1'b1}});
  assign full   = (fill == FW'(HEAP_DEPTH));
  assign fnd    = (s_ext == prev) && (prev != prev2);
  assign ft_inc = found_total + csrf_pkg::CNT_W'(1);

  always_comb begin
    st.can_step   = (halted == csrf_pkg::HALT_NONE) && (fill != '0);
    st.fill_zero  = (fill == '0);
    st.has_left   = ((FW+IW+1)'(lch) < (FW+IW+1)'(fill_x));
    st.has_right  = ((FW+IW+1)'(rch) < (FW+IW+1)'(fill_x));
    st.right_less = (rd_sum < c_sum);
    st.child_less = (c_sum < last_sum);
    st.at_root    = (idx == '0);
    st.up_less    = (val_sum < rd_sum);
    st.b_zero     = (b_pop == '0);
    st.halted_nz  = (halted != csrf_pkg::HALT_NONE);
    st.mul_done   = (mul_cnt == '0);
    st.succ_push  = (b3x2 < s_ext) && !ovf && !full;
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = {last_sum, last_root};
    raddr = '0;
    case (op)
      csrf_pkg::OP_GET_ROOT: raddr = fill[IW-1:0];
      csrf_pkg::OP_SD_L:     raddr = lch[IW-1:0];
      csrf_pkg::OP_SD_R:     raddr = rch[IW-1:0];
      csrf_pkg::OP_SD_CMP: begin
        we    = st.child_less;
        wdata = {c_sum, c_root};
      end
      csrf_pkg::OP_SD_PUT:   we = 1'b1;
      csrf_pkg::OP_PU_L:     raddr = par;
      csrf_pkg::OP_PU_CMP: begin
        we    = st.up_less;
        wdata = rd;
      end
      csrf_pkg::OP_PU_PUT: begin
        we    = 1'b1;
        wdata = {val_sum, val_root};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_written <= 1'b0;
      fill         <= FW'(1);
      next_base    <= RW'(2);
      base_cube    <= SW'(8);
      prev         <= '1;
      prev2        <= '1;
      found_total  <= '0;
      halted       <= csrf_pkg::HALT_NONE;
      stop_count   <= csrf_pkg::STOP_RESET;
      mul_cnt      <= '0;
      found        <= 1'b0;
      s_pop        <= '0;
      b_pop        <= '0;
    end else begin
      if (we && waddr == '0) begin
        root_written <= 1'b1;
      end
      if (cfg_we) begin
        stop_count <= cfg_data;
      end
      case (op)
        csrf_pkg::OP_START: begin
          found <= 1'b0;
          s_pop <= '0;
          b_pop <= '0;
        end
        csrf_pkg::OP_RD_ROOT:  fill <= fill - FW'(1);
        csrf_pkg::OP_GET_ROOT: begin
          s_pop <= rd_sum;
          b_pop <= rd_root;
        end
        csrf_pkg::OP_PU_START: fill <= fill + FW'(1);
        csrf_pkg::OP_BASE_ADV: begin
          if (next_base == {RW{1'b1}}) begin
            halted <= csrf_pkg::HALT_OVF;
          end else begin
            next_base <= next_base + RW'(1);
          end
        end
        csrf_pkg::OP_CUBE1, csrf_pkg::OP_CUBE2,
        csrf_pkg::OP_SQ, csrf_pkg::OP_B3: mul_cnt <= CW'(RW);
        csrf_pkg::OP_MUL_STEP: if (mul_cnt != '0) mul_cnt <= mul_cnt - CW'(1);
        csrf_pkg::OP_CUBE_ST: base_cube <= acc;
        csrf_pkg::OP_FOUND: begin
          if (fnd) begin
            found       <= 1'b1;
            found_total <= ft_inc;
            if (ft_inc == stop_count && halted == csrf_pkg::HALT_NONE) begin
              halted <= csrf_pkg::HALT_STOP;
            end
          end
          prev2 <= prev;
          prev  <= s_ext;
        end
        csrf_pkg::OP_SUCC: begin
          if (b3x2 < s_ext) begin
            if (ovf) begin
              halted <= csrf_pkg::HALT_OVF;
            end else if (full) begin
              halted <= csrf_pkg::HALT_FULL;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_init <= (raddr == '0) && !root_written;
    case (op)
      csrf_pkg::OP_GET_LAST: begin
        last_sum  <= rd_sum;
        last_root <= rd_root;
        idx       <= '0;
      end
      csrf_pkg::OP_SD_R: begin
        c_sum  <= rd_sum;
        c_root <= rd_root;
        c_idx  <= lch[IW-1:0];
      end
      csrf_pkg::OP_SD_CMP2: begin
        if (st.right_less) begin
          c_sum  <= rd_sum;
          c_root <= rd_root;
          c_idx  <= rch[IW-1:0];
        end
      end
      csrf_pkg::OP_SD_CMP: if (st.child_less) idx <= c_idx;
      csrf_pkg::OP_LOAD_BASE: begin
        val_sum  <= base_cube;
        val_root <= '0;
      end
      csrf_pkg::OP_PU_START: idx <= fill[IW-1:0];
      csrf_pkg::OP_PU_L:     par_idx <= par;
      csrf_pkg::OP_PU_CMP:   if (st.up_less) idx <= par_idx;
      csrf_pkg::OP_CUBE1: begin
        mul_a <= SW'(next_base);
        mul_b <= next_base;
        acc   <= '0;
      end
      csrf_pkg::OP_CUBE2: begin
        mul_a <= acc;
        mul_b <= next_base;
        acc   <= '0;
      end
      csrf_pkg::OP_SQ: begin
        mul_a <= SW'(b_pop);
        mul_b <= b_pop;
        acc   <= '0;
      end
      csrf_pkg::OP_B3: begin
        b2    <= acc;
        mul_a <= acc;
        mul_b <= b_pop;
        acc   <= '0;
      end
      csrf_pkg::OP_MUL_STEP: begin
        if (mul_cnt != '0) begin
          if (mul_b[0]) acc <= acc + mul_a;
          mul_a <= mul_a << 1;
          mul_b <= mul_b >> 1;
        end
      end
      csrf_pkg::OP_SUCC: begin
        val_sum  <= ns[SW-1:0];
        val_root <= b_pop + RW'(1);
      end
      default: ;
    endcase
  end

  logic [FW+csrf_pkg::SIZE_W-1:0] fill_wide;
  logic [RW+csrf_pkg::PB_W-1:0]   b_wide;
  assign fill_wide   = {{csrf_pkg::SIZE_W{1'b0}}, fill};
  assign b_wide      = {{csrf_pkg::PB_W{1'b0}}, b_pop};
  assign found_value = s_pop;
  assign partner_b   = b_wide[csrf_pkg::PB_W-1:0];
  assign ordinal     = found_total;
  assign heap_size   = fill_wide[csrf_pkg::SIZE_W-1:0];
  assign status      = halted;

endmodule

/* src/cube_sum_repeat_finder_unit.sv */
// ----------------------------------------------------------------------------
// cube_sum_repeat_finder_unit
// enumerates sums of two cubes in ascending order and reports repeated sums
// ----------------------------------------------------------------------------
// usage:
//   pulse start with step_request while busy is low. step_request 1 pops the
//   smallest sum from the heap, pushes its successors and checks for a repeat;
//   step_request 0, or a halted block, just reports the current counters.
//   one result per item, shown for one cycle with done high; the receiver
//   cannot stall, so results must be taken in that cycle.
//   each step sifts the popped entry down the heap level by level, sifts
//   each push up level by level and computes each cube (base cube and b
//   cube) on the shift-add multiplier; the heap ram port and the
//   multiplier set the step time.
//   stop_count sits at address 0 of the apb port; write it only while idle.
//   reset restores the heap to the single entry 1, counters to their start
//   values and stop_count to 1000000.
// ----------------------------------------------------------------------------
module cube_sum_repeat_finder_unit #(
  parameter int HEAP_DEPTH = csrf_pkg::HEAP_DEPTH_DEF,
  parameter int ROOT_WIDTH = csrf_pkg::ROOT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        step_request,
  output logic                        done,
  output logic                        found,
  output logic [csrf_pkg::SUM_W-1:0]  found_value,
  output logic [csrf_pkg::PB_W-1:0]   partner_b,
  output logic [csrf_pkg::CNT_W-1:0]  ordinal,
  output logic [csrf_pkg::SIZE_W-1:0] heap_size,
  output logic [1:0]                  status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  csrf_pkg::status_t            st;
  csrf_pkg::op_t                op;
  logic                         cfg_we;
  logic [csrf_pkg::CNT_W-1:0]   stop_count;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? '0 : stop_count;

  csrf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .step_request(step_request),
    .st(st), .op(op), .busy(busy), .done(done)
  );

  csrf_dp #(.HEAP_DEPTH(HEAP_DEPTH), .ROOT_WIDTH(ROOT_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .op(op), .cfg_we(cfg_we), .cfg_data(pwdata),
    .st(st), .stop_count(stop_count), .found(found),
    .found_value(found_value), .partner_b(partner_b), .ordinal(ordinal),
    .heap_size(heap_size), .status(status)
  );

endmodule
